@@ rtl/core/chc_pkg.sv @@
// ----------------------------------------------------------------------------
// chc_pkg: shared types and constants for the cache hit checker
// Geometry constants, register indexes, request/response payloads and the
// tag store entry layout.
// ----------------------------------------------------------------------------
package chc_pkg;

    // Geometry
    localparam int MAX_LINES   = 64;
    localparam int LINE_BYTES  = 64;
    // floor(log2) of the line size and of the line count
    localparam int OFFSET_BITS = $clog2(LINE_BYTES + 1) - 1;
    localparam int LINE_IDX_W  = $clog2(MAX_LINES + 1) - 1;
    localparam int NUM_LINES   = 1 << LINE_IDX_W;
    localparam int LB_W        = $clog2(LINE_IDX_W + 1);
    localparam int ADDR_W      = 32;
    localparam int TAG_W       = ADDR_W - OFFSET_BITS;
    localparam int STAMP_W     = 32;
    localparam int COUNT_W     = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAPPING_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPLIT_MODE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LINES_LOG2   = 2'd2;
    localparam logic [2:0]             LINES_LOG2_RESET = 3'd6;

    // Request and response payloads
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              is_instruction;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] access_count;
        logic [COUNT_W-1:0] hit_count;
    } rsp_t;

    // One tag store entry
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } line_entry_t;

    // Lines in use: zero acts as one, clamp to the store size
    function automatic logic [LB_W-1:0] lines_bits(input logic [2:0] l);
        int v;
        v = int'(l);
        if (v < 1) v = 1;
        if (v > LINE_IDX_W) v = LINE_IDX_W;
        return LB_W'(v);
    endfunction

    // Saturating increment
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (&v) ? v : v + COUNT_W'(1);
    endfunction

endpackage

@@ rtl/core/chc_ram.sv @@
// ----------------------------------------------------------------------------
// chc_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module chc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/cache_hit_checker_dm_fa_fifo_unit.sv @@
// ----------------------------------------------------------------------------
// cache_hit_checker_dm_fa_fifo_unit: direct-mapped / FIFO fully associative
// cache hit checker
// Decides hit or miss for one memory access per request and keeps running,
// saturating access and hit counts.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on s_valid/s_ready/s_data (address, instruction flag);
//   one response per request leaves on m_valid/m_ready/m_data (hit flag,
//   access count, hit count). Configuration is written through cfg_we,
//   cfg_index and cfg_data while the unit is idle.
//   A request walks its range of lines through the single read port of the
//   tag store, one line per cycle: one line in direct-mapped mode and every
//   line of the active range (up to 64) in fully associative mode. After
//   the scan, states S_LAST and S_UPDATE register the response; a new
//   request is taken the cycle after a response is registered.
//   Reset clears the valid bits of all lines at once (no clearing pass),
//   the counters and the configuration to its defaults.
//   While the receiver stalls, the finished response waits in the output
//   register; one more request may be accepted and is processed up to its
//   update step, where it waits until the output register is free.
// ----------------------------------------------------------------------------
module cache_hit_checker_dm_fa_fifo_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  chc_pkg::req_t                     s_data,
    // response channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output chc_pkg::rsp_t                     m_data,
    // configuration
    input  logic                              cfg_we,
    input  logic [chc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [chc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IW = chc_pkg::LINE_IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_LAST,
        S_UPDATE
    } state_t;

    // Configuration registers
    logic       mapping_reg;
    logic       split_reg;
    logic [2:0] lines_log2_reg;

    // Sequencer and datapath registers
    state_t                            state_reg;
    chc_pkg::req_t                     req_reg;
    logic [chc_pkg::TAG_W-1:0]         tag_reg;
    logic [IW-1:0]                     cnt_reg;
    logic [IW-1:0]                     start_reg;
    logic [IW-1:0]                     last_reg;
    logic                              p_valid_reg;
    logic [IW-1:0]                     p_idx_reg;
    logic                              hit_reg;
    logic                              inv_found_reg;
    logic                              have_min_reg;
    logic [chc_pkg::STAMP_W-1:0]       min_stamp_reg;
    logic [IW-1:0]                     victim_reg;
    logic [chc_pkg::NUM_LINES-1:0]     line_valid_reg;
    logic [chc_pkg::STAMP_W-1:0]       access_clock_reg;
    logic [chc_pkg::COUNT_W-1:0]       access_total_reg;
    logic [chc_pkg::COUNT_W-1:0]       hit_total_reg;
    logic                              m_valid_reg;
    chc_pkg::rsp_t                     m_data_reg;

    // Setup logic
    logic [chc_pkg::LB_W-1:0]          lb;
    logic [chc_pkg::LB_W-1:0]          sb;
    logic [IW-1:0]                     ones;
    logic [IW-1:0]                     span_mask;
    logic [IW-1:0]                     base;
    logic [IW-1:0]                     dm_line;
    logic [chc_pkg::TAG_W-1:0]         addr_tag;

    // Compare logic
    chc_pkg::line_entry_t              rd_entry;
    chc_pkg::line_entry_t              wr_entry;
    logic                              vbit;
    logic                              tag_match;
    logic                              stamp_less;
    logic                              out_free;
    logic                              ram_we;
    logic [chc_pkg::COUNT_W-1:0]       access_total_next;
    logic [chc_pkg::COUNT_W-1:0]       hit_total_next;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mapping_reg    <= 1'b0;
            split_reg      <= 1'b0;
            lines_log2_reg <= chc_pkg::LINES_LOG2_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                chc_pkg::REG_MAPPING_MODE: mapping_reg    <= cfg_data[0];
                chc_pkg::REG_SPLIT_MODE:   split_reg      <= cfg_data[0];
                chc_pkg::REG_LINES_LOG2:   lines_log2_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Geometry of the active range for the latched request
    always_comb begin
        ones      = '1;
        lb        = chc_pkg::lines_bits(lines_log2_reg);
        sb        = split_reg ? lb - chc_pkg::LB_W'(1) : lb;
        span_mask = ~(ones << sb);
        base      = (split_reg && req_reg.is_instruction) ? (IW'(1) << sb) : '0;
        dm_line   = base | (req_reg.address[chc_pkg::OFFSET_BITS +: IW] & span_mask);
        addr_tag  = req_reg.address[chc_pkg::ADDR_W-1:chc_pkg::OFFSET_BITS]
                    >> (mapping_reg ? chc_pkg::LB_W'(0) : sb);
    end

    // Shared compare unit on the line read back from the tag store
    always_comb begin
        vbit       = line_valid_reg[p_idx_reg];
        tag_match  = vbit && (rd_entry.tag == tag_reg);
        stamp_less = rd_entry.stamp < min_stamp_reg;
    end

    assign out_free          = !m_valid_reg || m_ready;
    assign ram_we            = (state_reg == S_UPDATE) && out_free && !hit_reg;
    assign access_total_next = chc_pkg::sat_inc(access_total_reg);
    assign hit_total_next    = hit_reg ? chc_pkg::sat_inc(hit_total_reg) : hit_total_reg;
    assign wr_entry.tag      = tag_reg;
    assign wr_entry.stamp    = access_clock_reg;

    // Tag and fill stamp store
    chc_ram #(
        .WIDTH ($bits(chc_pkg::line_entry_t)),
        .DEPTH (chc_pkg::NUM_LINES)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (victim_reg),
        .wdata (wr_entry),
        .raddr (cnt_reg),
        .rdata (rd_entry)
    );

    // Sequencer, scan bookkeeping, counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            p_valid_reg      <= 1'b0;
            hit_reg          <= 1'b0;
            inv_found_reg    <= 1'b0;
            have_min_reg     <= 1'b0;
            line_valid_reg   <= '0;
            access_clock_reg <= '0;
            access_total_reg <= '0;
            hit_total_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            p_valid_reg <= (state_reg == S_SCAN);
            p_idx_reg   <= cnt_reg;

            // response taken; an update step reloads the register itself
            if (m_valid_reg && m_ready && (state_reg != S_UPDATE)) begin
                m_valid_reg <= 1'b0;
            end

            // fold in the line read last cycle
            if (p_valid_reg) begin
                if (tag_match) begin
                    hit_reg <= 1'b1;
                end
                if (!inv_found_reg) begin
                    if (!vbit) begin
                        inv_found_reg <= 1'b1;
                        victim_reg    <= p_idx_reg;
                    end else if (!have_min_reg || stamp_less) begin
                        have_min_reg  <= 1'b1;
                        min_stamp_reg <= rd_entry.stamp;
                        victim_reg    <= p_idx_reg;
                    end
                end
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_data;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    tag_reg       <= addr_tag;
                    hit_reg       <= 1'b0;
                    inv_found_reg <= 1'b0;
                    have_min_reg  <= 1'b0;
                    if (mapping_reg) begin
                        cnt_reg   <= base;
                        start_reg <= base;
                        last_reg  <= base | span_mask;
                    end else begin
                        cnt_reg   <= dm_line;
                        start_reg <= dm_line;
                        last_reg  <= dm_line;
                    end
                    state_reg <= S_SCAN;
                end
                S_SCAN: begin
                    if (cnt_reg == last_reg) begin
                        state_reg <= S_LAST;
                    end else begin
                        cnt_reg <= cnt_reg + IW'(1);
                    end
                end
                S_LAST: begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (out_free) begin
                        if (!hit_reg) begin
                            line_valid_reg[victim_reg] <= 1'b1;
                        end
                        if (mapping_reg) begin
                            access_clock_reg <= access_clock_reg + chc_pkg::STAMP_W'(1);
                        end
                        access_total_reg        <= access_total_next;
                        hit_total_reg           <= hit_total_next;
                        m_data_reg.hit          <= hit_reg;
                        m_data_reg.access_count <= access_total_next;
                        m_data_reg.hit_count    <= hit_total_next;
                        m_valid_reg             <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_hits_le_accesses: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.hit_count <= m_data.access_count))
        else $error("hit count above access count");

    a_valid_never_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ($countones(line_valid_reg) >= $past($countones(line_valid_reg))))
        else $error("a line lost its valid mark");

    a_victim_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPDATE) |-> (victim_reg >= start_reg && victim_reg <= last_reg))
        else $error("replacement line outside the scanned range");

endmodule
